### src/kum_pkg.sv
// Shared constants and types of the Kruskal union-find MST block.
`default_nettype none
package kum_pkg;

	// Field widths
	localparam int VTX_W  = 11;
	localparam int WGT_W  = 32;
	localparam int TOT_W  = 42;
	localparam int RANK_W = 4;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Rank saturates here
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	// Default table depth
	localparam int MAX_VERTICES_DEF = 1024;

	// Configuration register map (register index = paddr[2])
	localparam logic REG_VCOUNT = 1'b0;
	localparam logic [VTX_W-1:0] VCOUNT_RST = 11'd1024;

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_FIND  = 7'b0001000,
		ST_COMP  = 7'b0010000,
		ST_UNION = 7'b0100000,
		ST_RANK  = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

### src/kum_table.sv
// Disjoint-set table memory: rank and parent per vertex, one write and one registered read port.
`default_nettype none
module kum_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port and registered read port (read returns old data on a same-address write)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### src/kum_ctrl.sv
// Sequencer for root finds, path compression, union by rank and the running total.
`default_nettype none
module kum_ctrl
	import kum_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	output logic                         done,
	input  wire logic [VTX_W-1:0]        first_end,
	input  wire logic [VTX_W-1:0]        second_end,
	input  wire logic signed [WGT_W-1:0] edge_weight,
	input  wire logic                    first_edge,
	input  wire logic                    last_edge,
	input  wire logic [VTX_W-1:0]        vertex_count,
	output logic                         joined,
	output logic signed [TOT_W-1:0]      tree_weight,
	output logic                         bad_vertex,
	output logic                         final_result
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW = AW + RANK_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

	state_t st_q;
	logic   pend_q;
	logic [VTX_W-1:0]        a_q, b_q;
	logic signed [WGT_W-1:0] w_q;
	logic                    last_q;
	logic                    side_q;
	logic [AW-1:0]           cur_q, walk_q, root_q, ra_q, rb_q, clr_q;
	logic [RANK_W-1:0]       rka_q, rkb_q;
	logic signed [TOT_W-1:0] total_q;
	logic                    done_q, joined_q, bad_q, final_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic [AW-1:0] rd_par;
	logic [RANK_W-1:0] rd_rank;
	logic [AW-1:0] a_idx, b_idx, start_idx;
	logic [AW-1:0] cmp_a, cmp_b;
	logic          eq;
	logic          bad;

	kum_table #(
		.DEPTH(MAX_VERTICES),
		.AW   (AW),
		.DW   (DW)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_par    = rdata[AW-1:0];
	assign rd_rank   = rdata[DW-1:AW];
	assign a_idx     = AW'(a_q - VTX_W'(1));
	assign b_idx     = AW'(b_q - VTX_W'(1));
	assign start_idx = side_q ? b_idx : a_idx;

	// Range check of both ends
	assign bad = (a_q == '0) || (b_q == '0) || (a_q > vertex_count) || (b_q > vertex_count) ||
		(32'(a_q) > 32'(MAX_VERTICES)) || (32'(b_q) > 32'(MAX_VERTICES));

	// Shared index comparator, operands picked by state
	always_comb begin
		cmp_a = cur_q;
		cmp_b = rd_par;
		case (st_q)
			ST_COMP: begin
				cmp_a = walk_q;
				cmp_b = root_q;
			end
			ST_UNION: begin
				cmp_a = ra_q;
				cmp_b = rb_q;
			end
			default: begin
				cmp_a = cur_q;
				cmp_b = rd_par;
			end
		endcase
	end
	assign eq = (cmp_a == cmp_b);

	// Table access
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = {{RANK_W{1'b0}}, clr_q};
		raddr = a_idx;
		case (st_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_CHECK: begin
				raddr = a_idx;
			end
			ST_FIND: begin
				raddr = eq ? start_idx : rd_par;
			end
			ST_COMP: begin
				if (!eq) begin
					we    = 1'b1;
					waddr = walk_q;
					wdata = {rd_rank, root_q};
					raddr = rd_par;
				end else begin
					raddr = b_idx;
				end
			end
			ST_UNION: begin
				if (!eq) begin
					we = 1'b1;
					if (rka_q > rkb_q) begin
						waddr = rb_q;
						wdata = {rkb_q, ra_q};
					end else begin
						waddr = ra_q;
						wdata = {rka_q, rb_q};
					end
				end
			end
			ST_RANK: begin
				we    = 1'b1;
				waddr = rb_q;
				wdata = {rkb_q + RANK_W'(1), rb_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Request payload latch
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			a_q    <= first_end;
			b_q    <= second_end;
			w_q    <= edge_weight;
			last_q <= last_edge;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			pend_q   <= 1'b0;
			clr_q    <= '0;
			side_q   <= 1'b0;
			cur_q    <= '0;
			walk_q   <= '0;
			root_q   <= '0;
			ra_q     <= '0;
			rb_q     <= '0;
			rka_q    <= '0;
			rkb_q    <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
			joined_q <= 1'b0;
			bad_q    <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						pend_q <= 1'b1;
						if (first_edge) begin
							clr_q   <= '0;
							total_q <= '0;
							st_q    <= ST_CLEAR;
						end else begin
							st_q <= ST_CHECK;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_IDX) begin
						pend_q <= 1'b0;
						st_q   <= pend_q ? ST_CHECK : ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (bad) begin
						joined_q <= 1'b0;
						bad_q    <= 1'b1;
						final_q  <= last_q;
						done_q   <= 1'b1;
						st_q     <= ST_IDLE;
					end else begin
						cur_q  <= a_idx;
						side_q <= 1'b0;
						st_q   <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (eq) begin
						root_q <= cur_q;
						walk_q <= start_idx;
						if (!side_q) begin
							ra_q  <= cur_q;
							rka_q <= rd_rank;
						end else begin
							rb_q  <= cur_q;
							rkb_q <= rd_rank;
						end
						st_q <= ST_COMP;
					end else begin
						cur_q <= rd_par;
					end
				end
				ST_COMP: begin
					if (eq) begin
						if (!side_q) begin
							side_q <= 1'b1;
							cur_q  <= b_idx;
							st_q   <= ST_FIND;
						end else begin
							st_q <= ST_UNION;
						end
					end else begin
						walk_q <= rd_par;
					end
				end
				ST_UNION: begin
					bad_q   <= 1'b0;
					final_q <= last_q;
					if (!eq) begin
						joined_q <= 1'b1;
						total_q  <= total_q + TOT_W'(w_q);
						if (rka_q == rkb_q && rkb_q < RANK_MAX) begin
							st_q <= ST_RANK;
						end else begin
							done_q <= 1'b1;
							st_q   <= ST_IDLE;
						end
					end else begin
						joined_q <= 1'b0;
						done_q   <= 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				ST_RANK: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (st_q != ST_IDLE);
	assign done         = done_q;
	assign joined       = joined_q;
	assign tree_weight  = total_q;
	assign bad_vertex   = bad_q;
	assign final_result = final_q;

`ifndef SYNTHESIS
	// One result pulse per request
	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A taken edge is never a bad one
	a_join_good: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(joined && bad_vertex))
		else $error("edge both joined and bad");

	// Compression writes always point at the root just found
	a_comp_root: assert property (@(posedge clk) disable iff (!arst_n)
		(we && st_q == ST_COMP) |-> (wdata[AW-1:0] == root_q))
		else $error("compression write not aimed at root");

	// An accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");
`endif

endmodule
`default_nettype wire

### src/kruskal_union_find_mst_top.sv
// Top level of the Kruskal MST block: configuration port and the union-find sequencer.
// Steps: an edge with a bad end is rejected by the range check; else each end's root is
//   found and its path compressed, then the union follows, with a rank bump on equal ranks.
// A first-edge request first rebuilds the table, one entry a cycle.
// Throughput: one edge at a time; the next request is taken in the cycle its result shows.
// Reset: busy while clearing the table; results strobe on done, no stall.
`default_nettype none
module kruskal_union_find_mst_top
	import kum_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	output logic                         done,
	input  wire logic [VTX_W-1:0]        first_end,
	input  wire logic [VTX_W-1:0]        second_end,
	input  wire logic signed [WGT_W-1:0] edge_weight,
	input  wire logic                    first_edge,
	input  wire logic                    last_edge,
	output logic                         joined,
	output logic signed [TOT_W-1:0]      tree_weight,
	output logic                         bad_vertex,
	output logic                         final_result,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic      [DATA_W-1:0]       prdata,
	output logic                         pready
);

	logic [VTX_W-1:0] vcount_q;
	logic             wr_req;

	assign pready = 1'b1;
	assign wr_req = psel && penable && pwrite;

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RST;
		end else if (wr_req && paddr[2] == REG_VCOUNT) begin
			vcount_q <= pwdata[VTX_W-1:0];
		end
	end

	// Read data
	always_comb begin
		if (paddr[2] == REG_VCOUNT) begin
			prdata = DATA_W'(vcount_q);
		end else begin
			prdata = '0;
		end
	end

	kum_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.first_end   (first_end),
		.second_end  (second_end),
		.edge_weight (edge_weight),
		.first_edge  (first_edge),
		.last_edge   (last_edge),
		.vertex_count(vcount_q),
		.joined      (joined),
		.tree_weight (tree_weight),
		.bad_vertex  (bad_vertex),
		.final_result(final_result)
	);

endmodule
`default_nettype wire
